// ===== design/hdt_pkg.sv =====
// ----------------------------------------------------------------------------
// hdt_pkg
// Shared types, constants and helpers for the HOTP dynamic truncation block.
// ----------------------------------------------------------------------------
package hdt_pkg;

  localparam int unsigned KeepBytes  = 19;
  localparam int unsigned CountW     = 5;
  localparam int unsigned PosW       = 5;
  localparam int unsigned AddrW      = PosW + 1;
  localparam int unsigned RamDepth   = 2 ** AddrW;
  localparam int unsigned CodeW      = 30;
  localparam int unsigned ValueW     = 31;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CountW-1:0] CountMax      = 5'd31;
  localparam logic [DigitW-1:0] DigitsAtReset = 4'd6;
  localparam logic [7:0]        TopByteMask   = 8'h7F;

  // One queued digest: which buffer bank holds it, the window offset and
  // whether the digest was too short for that window.
  typedef struct packed {
    logic       bank;
    logic [3:0] offset;
    logic       too_short;
  } job_t;

  // Ten to the power of the digit count; zero acts as one and above nine as nine.
  function automatic logic [CodeW-1:0] pow10(input logic [DigitW-1:0] digits);
    logic [CodeW-1:0] m;
    case (digits)
      4'd0, 4'd1: m = 30'd10;
      4'd2:       m = 30'd100;
      4'd3:       m = 30'd1000;
      4'd4:       m = 30'd10000;
      4'd5:       m = 30'd100000;
      4'd6:       m = 30'd1000000;
      4'd7:       m = 30'd10000000;
      4'd8:       m = 30'd100000000;
      default:    m = 30'd1000000000;
    endcase
    return m;
  endfunction

endpackage

// ===== design/hdt_ram.sv =====
// ----------------------------------------------------------------------------
// hdt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hdt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hdt_front.sv =====
// ----------------------------------------------------------------------------
// hdt_front
// Accepts digest bytes, writes the leading bytes into the current buffer bank,
// counts bytes and classifies each digest on its final byte.
// ----------------------------------------------------------------------------
module hdt_front import hdt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       digest_byte_i,
  input  logic             final_byte_i,
  input  logic             space_ok_i,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [7:0]       ram_wdata_o,
  output logic             push_o,
  output job_t             job_o
);

  logic [CountW-1:0] bytes_seen_q, bytes_seen_d;
  logic              bank_q, bank_d;
  logic              accept;
  logic [CountW-1:0] length;
  logic [3:0]        offset;
  logic [CountW:0]   needed;

  assign in_ready_o = space_ok_i;
  assign accept     = in_valid_i && in_ready_o;

  assign length = (bytes_seen_q == CountMax) ? CountMax : bytes_seen_q + 5'd1;
  assign offset = digest_byte_i[3:0];
  assign needed = {2'b00, offset} + 6'd4;

  assign ram_we_o    = accept && (bytes_seen_q < KeepBytes[CountW-1:0]);
  assign ram_waddr_o = {bank_q, bytes_seen_q};
  assign ram_wdata_o = digest_byte_i;

  assign push_o          = accept && final_byte_i;
  assign job_o.bank      = bank_q;
  assign job_o.offset    = offset;
  assign job_o.too_short = ({1'b0, length} < needed);

  always_comb begin
    bytes_seen_d = bytes_seen_q;
    bank_d       = bank_q;
    if (accept) begin
      if (final_byte_i) begin
        bytes_seen_d = '0;
        bank_d       = ~bank_q;
      end else begin
        bytes_seen_d = length;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      bank_q       <= 1'b0;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      bank_q       <= bank_d;
    end
  end

endmodule

// ===== design/hdt_queue.sv =====
// ----------------------------------------------------------------------------
// hdt_queue
// Two-entry job queue between the byte front end and the truncation back end.
// ----------------------------------------------------------------------------
module hdt_queue import hdt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       job_i,
  input  logic       pop_i,
  output logic       valid_o,
  output job_t       job_o,
  output logic [1:0] count_o
);

  job_t       entry_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign job_o   = entry_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> !push_i || pop_i)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue read while empty");
`endif

endmodule

// ===== design/hdt_back.sv =====
// ----------------------------------------------------------------------------
// hdt_back
// Reads the four-byte window of a queued digest, reduces it modulo a power of
// ten one bit per cycle and holds the result until taken; too short gives zero.
// ----------------------------------------------------------------------------
module hdt_back import hdt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DigitW-1:0] digit_count_i,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              busy_o,
  output logic [AddrW-1:0]  ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CodeW-1:0]  code_o,
  output logic              too_short_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRead = 3'b010,
    StDiv  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              bank_q;
  logic [3:0]        offset_q;
  logic [CodeW-1:0]  mod_q;
  logic [31:0]       value_q;
  logic [CodeW-1:0]  rem_q;
  logic              out_valid_q;
  logic [CodeW-1:0]  code_q;
  logic              too_short_q;

  logic [PosW-1:0]   rd_pos;
  logic [7:0]        in_byte;
  logic [ValueW-1:0] trial;
  logic [ValueW-1:0] diff;
  logic              ge;
  logic [CodeW-1:0]  rem_next;

  assign pop_o  = (state_q == StIdle) && job_valid_i && !out_valid_q;
  assign busy_o = (state_q != StIdle);

  assign rd_pos      = {1'b0, offset_q} + {3'b000, cnt_q[1:0]};
  assign ram_raddr_o = {bank_q, rd_pos};

  // The first byte of the window loses its top bit.
  assign in_byte = (cnt_q == 5'd1) ? (ram_rdata_i & TopByteMask) : ram_rdata_i;

  // One restoring division step: the remainder always stays below the modulus.
  assign trial    = {rem_q, value_q[ValueW-1]};
  assign diff     = trial - {1'b0, mod_q};
  assign ge       = (trial >= {1'b0, mod_q});
  assign rem_next = ge ? diff[CodeW-1:0] : trial[CodeW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (pop_o && !job_i.too_short) begin
          state_d = StRead;
          cnt_d   = '0;
        end
      end
      StRead: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd4) begin
          state_d = StDiv;
          cnt_d   = '0;
        end
      end
      StDiv: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(ValueW - 1)) begin
          state_d = StIdle;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = StIdle;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        bank_q   <= job_i.bank;
        offset_q <= job_i.offset;
        mod_q    <= pow10(digit_count_i);
        rem_q    <= '0;
      end
      StRead: begin
        if (cnt_q != 5'd0) begin
          value_q <= {value_q[23:0], in_byte};
        end
      end
      StDiv: begin
        rem_q   <= rem_next;
        value_q <= {value_q[30:0], 1'b0};
      end
      default: begin
        rem_q <= '0;
      end
    endcase
    if (pop_o && job_i.too_short) begin
      code_q      <= '0;
      too_short_q <= 1'b1;
    end else if (state_q == StDiv && cnt_q == 5'(ValueW - 1)) begin
      code_q      <= rem_next;
      too_short_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if ((pop_o && job_i.too_short) || (state_q == StDiv && cnt_q == 5'(ValueW - 1))) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;
  assign too_short_o = too_short_q;

`ifndef SYNTHESIS
  a_rem_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < mod_q))
    else $error("remainder reached the modulus during division");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == 5'(ValueW - 1)) |-> !out_valid_q)
    else $error("division finished while the previous result was still held");
`endif

endmodule

// ===== design/hotp_dynamic_truncation.sv =====
// ----------------------------------------------------------------------------
// hotp_dynamic_truncation
// HOTP dynamic truncation of an HMAC digest delivered one byte per transaction.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   digest_byte_i, final_byte_i
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_digit_count_i
//   out      output     out_valid_o / out_ready_i code_o, too_short_o
//
// Digest bytes are taken one per cycle while in_ready_o is high. The front end
// writes the first 19 bytes into one of two buffer banks, so a new digest
// streams in while the back end works on the previous one. The back end picks
// up a job, reads the four window bytes from the RAM with registered data and
// then does the bit-serial modulo; a too-short digest is done at pick-up.
// The next job is picked up only after the held result has been taken.
// Input stalls while two digests are open, queued or being reduced, since each
// holds a buffer bank. No clearing pass after reset.
// ----------------------------------------------------------------------------
module hotp_dynamic_truncation import hdt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        digest_byte_i,
  input  logic              final_byte_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DigitW-1:0] cfg_digit_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CodeW-1:0]  code_o,
  output logic              too_short_o
);

  logic [DigitW-1:0] digit_count_q;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [7:0]        ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;
  logic              push;
  job_t              push_job;
  logic              pop;
  logic              q_valid;
  job_t              q_job;
  logic [1:0]        q_count;
  logic              back_busy;
  logic [2:0]        jobs_open;
  logic              space_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= DigitsAtReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      digit_count_q <= cfg_digit_count_i;
    end
  end

  // Each open job owns one bank; with two open the bank being filled is taken.
  assign jobs_open = {1'b0, q_count} + {2'b00, back_busy};
  assign space_ok  = (jobs_open < 3'd2);

  hdt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .digest_byte_i(digest_byte_i),
    .final_byte_i (final_byte_i),
    .space_ok_i   (space_ok),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .push_o       (push),
    .job_o        (push_job)
  );

  hdt_ram #(
    .Width(8),
    .Depth(RamDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  hdt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .valid_o(q_valid),
    .job_o  (q_job),
    .count_o(q_count)
  );

  hdt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .digit_count_i(digit_count_q),
    .job_valid_i  (q_valid),
    .job_i        (q_job),
    .pop_o        (pop),
    .busy_o       (back_busy),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_o       (code_o),
    .too_short_o  (too_short_o)
  );

`ifndef SYNTHESIS
  a_short_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_short_o) |-> (code_o == '0))
    else $error("too-short result carries a nonzero code");

  a_code_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !too_short_o) |-> (code_o < 30'd1000000000))
    else $error("code exceeds nine decimal digits");
`endif

endmodule
